/* sv/bitmap_command_coprocessor_defines.svh */
// ----------------------------------------------------------------------------
// Bitmap command coprocessor assertion macros
// Shared assertion macros for the coprocessor RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_COMMAND_COPROCESSOR_DEFINES_SVH
`define BITMAP_COMMAND_COPROCESSOR_DEFINES_SVH

// Asserts that an antecedent implies a consequent on the next clock.
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Asserts that a condition holds at every clock outside reset.
`define BCC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

/* sv/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap command coprocessor package
// Command codes and constants shared by the coprocessor RTL.
// ----------------------------------------------------------------------------
package bcc_pkg;
  localparam logic [7:0] CMD_PLANAR   = 8'h01;
  localparam logic [7:0] CMD_TRANSP   = 8'h03;
  localparam logic [7:0] CMD_OVERLAY  = 8'h05;
  localparam logic [7:0] CMD_MIRROR   = 8'h06;
  localparam logic [7:0] CMD_MULTIPLY = 8'h09;
  localparam logic [7:0] CMD_SCALE    = 8'h0d;
  localparam logic [7:0] EMPTY_BYTE   = 8'hff;
  localparam logic [7:0] FUNC_READ    = 8'h00;
  typedef logic [7:0] byte_t;
endpackage

/* sv/bitmap_command_coprocessor.sv */
// ----------------------------------------------------------------------------
// Bitmap command coprocessor
// Byte-wide command port with planar conversion, overlay, mirror, multiply
// and row scaling, run by a small sequencer over one shared datapath.
// ----------------------------------------------------------------------------
// Usage: a transfer is accepted when start is high and busy is low. in_func
// selects a read (0) or a write (1) of in_data. A read gives one byte on
// out_read_data with out_valid high for one cycle, after the sequencer
// passes through S_RD and S_RDOUT; 0xff is returned once the output is
// exhausted. A write gives no result. The write that completes a header
// also passes through S_HDR0, S_HDR1 and S_HDR2 with busy high. The write
// that completes a command starts its execution, which walks the output one
// byte per step through planar conversion, overlay, mirror, scale and the
// multiply; the scale step comes from a restoring divider. busy stays high
// meanwhile. After reset the block sweeps the input memory to zero, one
// entry per cycle, until all INPUT_DEPTH entries are cleared, with busy
// high. The receiver cannot stall: each result is present for exactly one
// cycle.
// ----------------------------------------------------------------------------
`include "bitmap_command_coprocessor_defines.svh"

module bitmap_command_coprocessor
  import bcc_pkg::*;
#(
  parameter int INPUT_DEPTH  = 512,
  parameter int OUTPUT_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_func,
  input  logic [7:0] in_data,
  output logic       out_valid,
  output logic [7:0] out_read_data
);
  localparam int IAW = $clog2(INPUT_DEPTH);
  localparam int OAW = $clog2(OUTPUT_DEPTH);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_RDOUT = 5'd3;
  localparam logic [4:0] S_HDR0  = 5'd4;
  localparam logic [4:0] S_HDR1  = 5'd5;
  localparam logic [4:0] S_HDR2  = 5'd6;
  localparam logic [4:0] S_RUN   = 5'd7;
  localparam logic [4:0] S_P_RD  = 5'd8;
  localparam logic [4:0] S_P_AC  = 5'd9;
  localparam logic [4:0] S_P_WR  = 5'd10;
  localparam logic [4:0] S_O_RA  = 5'd11;
  localparam logic [4:0] S_O_RB  = 5'd12;
  localparam logic [4:0] S_O_WR  = 5'd13;
  localparam logic [4:0] S_M_RD  = 5'd14;
  localparam logic [4:0] S_M_WR  = 5'd15;
  localparam logic [4:0] S_X_RD  = 5'd16;
  localparam logic [4:0] S_X_MUL = 5'd17;
  localparam logic [4:0] S_X_WR  = 5'd18;
  localparam logic [4:0] S_DIV   = 5'd19;
  localparam logic [4:0] S_S_PX  = 5'd20;
  localparam logic [4:0] S_S_RD  = 5'd21;
  localparam logic [4:0] S_S_WR  = 5'd22;
  localparam logic [4:0] S_T_RD  = 5'd23;
  localparam logic [4:0] S_T_WR  = 5'd24;

  logic [4:0]  state_r, state_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [9:0]  need_r, need_nxt;
  logic [9:0]  recv_r, recv_nxt;
  logic        payload_r, payload_nxt;
  logic [7:0]  rlen_r, rlen_nxt;
  logic [7:0]  slen_r, slen_nxt;
  logic [3:0]  tcol_r, tcol_nxt;
  logic [8:0]  rptr_r, rptr_nxt;
  logic [8:0]  avail_r, avail_nxt;
  logic [IAW:0] clr_r, clr_nxt;
  logic [8:0]  i_r, i_nxt;
  logic [5:0]  j_r, j_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [25:0] quo_r, quo_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [24:0] step_r, step_nxt;
  logic [33:0] pos_r, pos_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  rd_r, rd_nxt;

  logic [7:0]  imem [INPUT_DEPTH];
  logic [7:0]  omem [OUTPUT_DEPTH];
  logic [7:0]  idata_r, odata_r;
  logic        iwe;
  logic [IAW-1:0] iwa, ira;
  logic [7:0]  iwd;
  logic        owe;
  logic [OAW-1:0] owa, ora;
  logic [7:0]  owd;

  always_ff @(posedge clk) begin
    if (iwe) begin
      imem[iwa] <= iwd;
    end
    idata_r <= imem[ira];
  end

  always_ff @(posedge clk) begin
    if (owe) begin
      omem[owa] <= owd;
    end
    odata_r <= omem[ora];
  end

  logic [25:0] dsub;
  logic [26:0] rem_sh;
  logic [8:0]  div_d;
  logic [33:0] px_idx;
  logic [2:0]  row_i;
  logic [2:0]  x_i;
  logic [1:0]  pl_i;
  logic [3:0]  px_val;

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; need_nxt = need_r; recv_nxt = recv_r;
    payload_nxt = payload_r; rlen_nxt = rlen_r; slen_nxt = slen_r; tcol_nxt = tcol_r;
    rptr_nxt = rptr_r; avail_nxt = avail_r; clr_nxt = clr_r; i_nxt = i_r; j_nxt = j_r;
    acc_nxt = acc_r; hold_nxt = hold_r; prod_nxt = prod_r; quo_nxt = quo_r;
    rem_nxt = rem_r; step_nxt = step_r; pos_nxt = pos_r; ov_nxt = 1'b0; rd_nxt = rd_r;
    iwe = 1'b0; iwa = '0; iwd = '0; ira = '0;
    owe = 1'b0; owa = '0; owd = '0; ora = '0;
    div_d = {slen_r, 1'b1};
    rem_sh = {rem_r, quo_r[25]};
    dsub = rem_sh[25:0] - {17'd0, div_d};
    px_idx = pos_r >> 16;
    row_i = i_r[3:1];
    x_i = j_r[4:2];
    pl_i = j_r[1:0];
    px_val = x_i[0] ? idata_r[3:0] : idata_r[7:4];
    case (state_r)
      S_CLEAR: begin
        iwe = 1'b1;
        iwa = clr_r[IAW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IAW+1)'(INPUT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!in_func) begin
            state_nxt = S_RD;
          end else if (need_r == 10'd0) begin
            cmd_nxt = in_data;
            recv_nxt = 10'd0;
            payload_nxt = 1'b0;
            case (in_data)
              CMD_PLANAR: need_nxt = 10'd32;
              CMD_TRANSP, CMD_OVERLAY, CMD_MIRROR: need_nxt = 10'd1;
              CMD_MULTIPLY: need_nxt = 10'd4;
              CMD_SCALE: need_nxt = 10'd2;
              default: need_nxt = need_r;
            endcase
          end else begin
            iwe = 1'b1;
            iwa = recv_r[IAW-1:0];
            iwd = in_data;
            recv_nxt = recv_r + 10'd1;
            if (recv_r + 10'd1 == need_r) begin
              need_nxt = 10'd0;
              if (!payload_r && (cmd_r == CMD_OVERLAY || cmd_r == CMD_MIRROR
                                 || cmd_r == CMD_SCALE)) begin
                state_nxt = S_HDR0;
              end else begin
                state_nxt = S_RUN;
              end
            end
          end
        end
      end
      S_RD: begin
        ora = rptr_r[OAW-1:0];
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        ov_nxt = 1'b1;
        if (rptr_r < avail_r) begin
          rd_nxt = odata_r;
          rptr_nxt = rptr_r + 9'd1;
        end else begin
          rd_nxt = EMPTY_BYTE;
        end
        state_nxt = S_IDLE;
      end
      S_HDR0: begin
        ira = '0;
        state_nxt = S_HDR1;
      end
      S_HDR1: begin
        rlen_nxt = idata_r;
        ira = IAW'(1);
        state_nxt = S_HDR2;
      end
      S_HDR2: begin
        slen_nxt = (cmd_r == CMD_SCALE) ? idata_r : rlen_r;
        recv_nxt = 10'd0;
        payload_nxt = 1'b1;
        if (cmd_r == CMD_OVERLAY) begin
          need_nxt = {1'b0, rlen_r, 1'b0};
        end else if (cmd_r == CMD_MIRROR) begin
          need_nxt = {2'd0, rlen_r};
        end else begin
          need_nxt = 10'(({1'b0, rlen_r} + 9'd1) >> 1);
        end
        if (rlen_r == 8'd0 || slen_nxt == 8'd0) begin
          need_nxt = 10'd0;
          avail_nxt = 9'd0;
          rptr_nxt = 9'd0;
        end
        state_nxt = S_IDLE;
      end
      S_RUN: begin
        rptr_nxt = 9'd0;
        avail_nxt = 9'd0;
        i_nxt = '0;
        j_nxt = '0;
        acc_nxt = '0;
        case (cmd_r)
          CMD_PLANAR: state_nxt = S_P_RD;
          CMD_TRANSP: state_nxt = S_T_RD;
          CMD_OVERLAY: state_nxt = (rlen_r == 8'd0) ? S_IDLE : S_O_RA;
          CMD_MIRROR: state_nxt = (rlen_r == 8'd0) ? S_IDLE : S_M_RD;
          CMD_MULTIPLY: state_nxt = S_X_RD;
          CMD_SCALE: begin
            if (slen_r == 8'd0) begin
              state_nxt = S_IDLE;
            end else if (rlen_r <= slen_r) begin
              step_nxt = 25'h10000;
              pos_nxt = '0;
              state_nxt = S_S_PX;
            end else begin
              quo_nxt = {1'b0, rlen_r, 17'd0};
              rem_nxt = '0;
              j_nxt = 6'd26;
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // Planar: i is the output byte (0..31); j walks x and plane bits.
      S_P_RD: begin
        ira = IAW'({row_i, 2'b00} + {3'd0, x_i[2:1]});
        state_nxt = S_P_AC;
      end
      S_P_AC: begin
        if ({i_r[4], i_r[0]} == pl_i) begin
          acc_nxt = acc_r | ({7'd0, px_val[pl_i]} << (3'd7 - x_i));
        end
        j_nxt = j_r + 6'd1;
        state_nxt = (j_r == 6'd31) ? S_P_WR : S_P_RD;
      end
      S_P_WR: begin
        owe = 1'b1;
        owa = OAW'(i_r[4:0]);
        owd = acc_r;
        acc_nxt = '0;
        j_nxt = '0;
        i_nxt = i_r + 9'd1;
        if (i_r == 9'd31) begin
          avail_nxt = 9'd32;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      S_T_RD: begin
        ira = '0;
        state_nxt = S_T_WR;
      end
      S_T_WR: begin
        tcol_nxt = idata_r[3:0];
        state_nxt = S_IDLE;
      end
      S_O_RA: begin
        ira = IAW'({1'b0, rlen_r} + i_r);
        state_nxt = S_O_RB;
      end
      S_O_RB: begin
        hold_nxt = idata_r;
        ira = IAW'(i_r);
        state_nxt = S_O_WR;
      end
      S_O_WR: begin
        owe = 1'b1;
        owa = OAW'(i_r);
        owd[3:0] = (hold_r[3:0] == tcol_r) ? idata_r[3:0] : hold_r[3:0];
        owd[7:4] = (hold_r[7:4] == tcol_r) ? idata_r[7:4] : hold_r[7:4];
        i_nxt = i_r + 9'd1;
        if (i_r + 9'd1 == {1'b0, rlen_r}) begin
          avail_nxt = {1'b0, rlen_r};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_O_RA;
        end
      end
      S_M_RD: begin
        ira = IAW'({1'b0, rlen_r} - 9'd1 - i_r);
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        owe = 1'b1;
        owa = OAW'(i_r);
        owd = {idata_r[3:0], idata_r[7:4]};
        i_nxt = i_r + 9'd1;
        if (i_r + 9'd1 == {1'b0, rlen_r}) begin
          avail_nxt = {1'b0, rlen_r};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_M_RD;
        end
      end
      // Multiply: read four bytes into prod, then shift-add 16 steps.
      S_X_RD: begin
        ira = IAW'(i_r);
        if (i_r != 9'd0) begin
          prod_nxt = {idata_r, prod_r[31:8]};
        end
        i_nxt = i_r + 9'd1;
        if (i_r == 9'd4) begin
          quo_nxt = {10'd0, prod_nxt[31:16]};
          prod_nxt = {16'd0, prod_nxt[15:0]};
          i_nxt = '0;
          j_nxt = 6'd16;
          state_nxt = S_X_MUL;
        end
      end
      S_X_MUL: begin
        prod_nxt = {1'b0, prod_r[31:1]};
        if (prod_r[0]) begin
          prod_nxt = {({1'b0, prod_r[31:16]} + {1'b0, quo_r[15:0]}), prod_r[15:1]};
        end
        j_nxt = j_r - 6'd1;
        if (j_r == 6'd1) begin
          state_nxt = S_X_WR;
        end
      end
      S_X_WR: begin
        owe = 1'b1;
        owa = OAW'(i_r);
        owd = prod_r[7:0];
        prod_nxt = {8'd0, prod_r[31:8]};
        i_nxt = i_r + 9'd1;
        if (i_r == 9'd3) begin
          avail_nxt = 9'd4;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!dsub[25] || rem_sh[26]) begin
          rem_nxt = dsub;
          quo_nxt = {quo_r[24:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[25:0];
          quo_nxt = {quo_r[24:0], 1'b0};
        end
        j_nxt = j_r - 6'd1;
        if (j_r == 6'd1) begin
          step_nxt = quo_nxt[24:0];
          pos_nxt = '0;
          state_nxt = S_S_PX;
        end
      end
      S_S_PX: begin
        ira = IAW'(px_idx[33:1]);
        hold_nxt = {7'd0, px_idx[0]};
        state_nxt = S_S_RD;
      end
      S_S_RD: begin
        acc_nxt = {acc_r[3:0], hold_r[0] ? idata_r[3:0] : idata_r[7:4]};
        pos_nxt = pos_r + {9'd0, step_r};
        j_nxt = j_r + 6'd1;
        state_nxt = j_r[0] ? S_S_WR : S_S_PX;
      end
      S_S_WR: begin
        owe = 1'b1;
        owa = OAW'(i_r);
        owd = acc_r;
        i_nxt = i_r + 9'd1;
        if (i_r + 9'd1 == {1'b0, slen_r}) begin
          avail_nxt = {1'b0, slen_r};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_S_PX;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cmd_r <= '0; need_r <= '0; recv_r <= '0; payload_r <= 1'b0;
      rlen_r <= '0; slen_r <= '0; tcol_r <= '0; rptr_r <= '0; avail_r <= '0;
      clr_r <= '0; i_r <= '0; j_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cmd_r <= cmd_nxt; need_r <= need_nxt; recv_r <= recv_nxt;
      payload_r <= payload_nxt; rlen_r <= rlen_nxt; slen_r <= slen_nxt;
      tcol_r <= tcol_nxt; rptr_r <= rptr_nxt; avail_r <= avail_nxt; clr_r <= clr_nxt;
      i_r <= i_nxt; j_r <= j_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; hold_r <= hold_nxt; prod_r <= prod_nxt; quo_r <= quo_nxt;
    rem_r <= rem_nxt; step_r <= step_nxt; pos_r <= pos_nxt; rd_r <= rd_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_read_data = rd_r;

  `BCC_ASSERT_NEXT(a_read_result, clk, rst_n,
                   start && !busy && in_func == FUNC_READ[0], busy)
  `BCC_ASSERT_ALWAYS(a_ptr_bound, clk, rst_n, rptr_r <= avail_r || avail_r == 9'd0)
  `BCC_ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
endmodule

/* tb/sv/tb_bitmap_command_coprocessor.sv */
// ----------------------------------------------------------------------------
// Bitmap command coprocessor testbench
// Drives bus reads and writes through the command port, predicts every read
// byte with a behavioral model of the command sequencer and checks each
// result in order.
// ----------------------------------------------------------------------------
module tb_bitmap_command_coprocessor;
  import bcc_pkg::*;

  localparam int IN_DEPTH  = 512;
  localparam int OUT_DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_ERR_PRINT = 10;
  localparam logic FN_READ  = 1'b0;
  localparam logic FN_WRITE = 1'b1;

  class coproc_scoreboard;
    byte_t     pending_bytes[$];
    byte_t     cmd;
    int unsigned need;
    int unsigned got;
    bit        in_payload;
    int unsigned row_len;
    int unsigned scaled_len;
    logic [3:0] transp;
    byte_t     in_mem[IN_DEPTH];
    byte_t     out_mem[OUT_DEPTH];
    int unsigned rd_ptr;
    int unsigned avail;
    int        mismatches;

    function void clear();
      cmd = 0; need = 0; got = 0; in_payload = 0; row_len = 0;
      scaled_len = 0; transp = 0; rd_ptr = 0; avail = 0; mismatches = 0;
      foreach (in_mem[i]) in_mem[i] = 0;
      foreach (out_mem[i]) out_mem[i] = 0;
    endfunction

    function byte_t in_at(longint unsigned i);
      return in_mem[i % IN_DEPTH];
    endfunction

    function void execute();
      longint unsigned a, b, p, step, px;
      int unsigned ov, pix, res, packed_px, off;
      rd_ptr = 0;
      avail = 0;
      case (cmd)
        CMD_PLANAR: begin
          foreach (out_mem[i]) out_mem[i] = 0;
          for (int r = 0; r < 8; r++)
            for (int x = 0; x < 8; x++) begin
              pix = (in_at(r * 4 + x / 2) >> ((x & 1) ? 0 : 4)) & 15;
              for (int pl = 0; pl < 4; pl++) begin
                off = (pl / 2) * 16 + r * 2 + pl % 2;
                out_mem[off] = out_mem[off] | (((pix >> pl) & 1) << (7 - x));
              end
            end
          avail = 32;
        end
        CMD_TRANSP: transp = in_at(0) & 15;
        CMD_OVERLAY: begin
          for (int i = 0; i < row_len; i++) begin
            res = 0;
            for (int k = 0; k < 8; k += 4) begin
              ov = (in_at(row_len + i) >> k) & 15;
              pix = (ov == transp) ? ((in_at(i) >> k) & 15) : ov;
              res |= pix << k;
            end
            out_mem[i % OUT_DEPTH] = res[7:0];
          end
          avail = row_len;
        end
        CMD_MIRROR: begin
          for (int i = 0; i < row_len; i++) begin
            res = in_at(row_len - 1 - i);
            out_mem[i % OUT_DEPTH] = {res[3:0], res[7:4]};
          end
          avail = row_len;
        end
        CMD_MULTIPLY: begin
          a = {in_at(1), in_at(0)};
          b = {in_at(3), in_at(2)};
          p = (a * b) & 64'hffff_ffff;
          for (int i = 0; i < 4; i++) out_mem[i] = p >> (i * 8);
          avail = 4;
        end
        CMD_SCALE: begin
          step = (row_len <= scaled_len) ? 64'h10000 :
                 (longint'(row_len) << 17) / (longint'(scaled_len) * 2 + 1);
          for (int i = 0; i < scaled_len; i++) begin
            packed_px = 0;
            for (int k = 0; k < 2; k++) begin
              px = ((longint'(i) * 2 + k) * step) >> 16;
              packed_px = (packed_px << 4) | ((in_at(px / 2) >> ((px & 1) ? 0 : 4)) & 15);
            end
            out_mem[i % OUT_DEPTH] = packed_px[7:0];
          end
          avail = scaled_len;
        end
        default: ;
      endcase
    endfunction

    function void note_transfer(logic fn, byte_t d);
      if (fn == FN_READ) begin
        if (rd_ptr < avail) begin
          pending_bytes.push_back(out_mem[rd_ptr % OUT_DEPTH]);
          rd_ptr = (rd_ptr + 1) & 9'h1ff;
        end else begin
          pending_bytes.push_back(EMPTY_BYTE);
        end
        return;
      end
      if (need == 0) begin
        cmd = d; got = 0; in_payload = 0;
        case (d)
          CMD_PLANAR: need = 32;
          CMD_TRANSP, CMD_OVERLAY, CMD_MIRROR: need = 1;
          CMD_MULTIPLY: need = 4;
          CMD_SCALE: need = 2;
          default: ;
        endcase
        return;
      end
      in_mem[got % IN_DEPTH] = d;
      got = (got + 1) & 10'h3ff;
      if (got != need) return;
      need = 0;
      if (!in_payload && (cmd == CMD_OVERLAY || cmd == CMD_MIRROR || cmd == CMD_SCALE)) begin
        row_len = in_mem[0];
        scaled_len = (cmd == CMD_SCALE) ? in_mem[1] : row_len;
        if (cmd == CMD_OVERLAY) need = row_len * 2;
        else if (cmd == CMD_MIRROR) need = row_len;
        else need = (row_len + 1) / 2;
        got = 0;
        in_payload = 1;
        if (row_len == 0 || scaled_len == 0) begin
          need = 0; avail = 0; rd_ptr = 0;
        end
        return;
      end
      execute();
    endfunction

    function void check_byte(byte_t actual);
      byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERR_PRINT)
          $display("ERROR: unexpected read byte 0x%02h", actual);
        return;
      end
      exp_b = pending_bytes.pop_front();
      if (exp_b !== actual) begin
        mismatches++;
        if (mismatches <= MAX_ERR_PRINT)
          $display("ERROR: read_data expected 0x%02h actual 0x%02h", exp_b, actual);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       start = 0;
  logic       busy;
  logic       in_func = 0;
  logic [7:0] in_data = 0;
  logic       out_valid;
  logic [7:0] out_read_data;

  coproc_scoreboard sb;
  int  idle_pct = 18;
  int  idle_cycles = 0;
  int  issued = 0;
  bit  done_driving = 0;
  bit  paused = 0;

  always #5 clk = ~clk;

  bitmap_command_coprocessor u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_data(in_data),
    .out_valid(out_valid), .out_read_data(out_read_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_transfer(in_func, in_data);
      if (out_valid) sb.check_byte(out_read_data);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One bus transfer; start stays high across back-to-back transfers.
  task automatic bus_transfer(logic fn, byte_t d);
    while (!(issued > 300 && issued < 420) && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_func <= fn;
    in_data <= fn ? d : byte_t'($urandom);
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  task automatic write_seq(byte_t bytes[$]);
    foreach (bytes[i]) bus_transfer(FN_WRITE, bytes[i]);
  endtask

  task automatic read_out(int n);
    for (int i = 0; i < n; i++) bus_transfer(FN_READ, 0);
  endtask

  task automatic rand_command();
    byte_t s[$];
    int len, sl, pick;
    pick = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
    if (pick < 15) begin
      s.push_back(CMD_PLANAR);
      for (int i = 0; i < 32; i++) s.push_back($urandom);
    end else if (pick < 25) begin
      s = '{CMD_TRANSP, byte_t'($urandom)};
    end else if (pick < 42) begin
      s = '{CMD_OVERLAY, byte_t'(len)};
      for (int i = 0; i < 2 * len; i++)
        s.push_back(($urandom_range(1)) ? {sb.transp, 4'($urandom)} : byte_t'($urandom));
    end else if (pick < 57) begin
      s = '{CMD_MIRROR, byte_t'(len)};
      for (int i = 0; i < len; i++) s.push_back($urandom);
    end else if (pick < 70) begin
      s = '{CMD_MULTIPLY, byte_t'($urandom), byte_t'($urandom),
            byte_t'($urandom), byte_t'($urandom)};
    end else if (pick < 88) begin
      sl = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      s = '{CMD_SCALE, byte_t'(len), byte_t'(sl)};
      for (int i = 0; i < (len + 1) / 2; i++) s.push_back($urandom);
    end else begin
      s.push_back($urandom);
    end
    // Occasionally cut the sequence short to leave a command pending.
    if ($urandom_range(19) == 0 && s.size() > 2) s = s[0:$urandom_range(s.size() - 2, 1)];
    write_seq(s);
    read_out($urandom_range(6) == 0 ? $urandom_range(40) : $urandom_range(6));
  endtask

  initial begin
    byte_t s[$];
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);

    read_out(2);
    s = '{CMD_SCALE, 8'd20, 8'd40};
    for (int i = 0; i < 10; i++) s.push_back(8'hff);
    write_seq(s);
    read_out(41);
    s = '{CMD_MULTIPLY, 8'hff, 8'hff, 8'hff, 8'hff};
    write_seq(s);
    read_out(5);
    write_seq('{CMD_TRANSP, 8'h0a});
    write_seq('{CMD_OVERLAY, 8'd2, 8'h12, 8'h34, 8'haa, 8'h5a});
    read_out(3);
    write_seq('{CMD_MIRROR, 8'd0});
    read_out(1);
    write_seq('{8'h77, CMD_MIRROR, 8'd2, 8'h12, 8'hf0});
    read_out(3);
    write_seq('{CMD_SCALE, 8'd9, 8'd3, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a});
    read_out(3);
    s = '{CMD_PLANAR};
    for (int i = 0; i < 32; i++) s.push_back(i[0] ? 8'hff : 8'h00);
    write_seq(s);
    read_out(4);

    while (issued < 800) begin
      if (issued > 500 && !paused) begin
        start <= 0;
        paused = 1;
        while (sb.pending_bytes.size() != 0) @(posedge clk);
      end
      rand_command();
    end
    start <= 0;
    done_driving = 1;
  end

  initial begin
    wait (done_driving);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/bcc_pkg.sv
sv/bitmap_command_coprocessor.sv
tb/sv/tb_bitmap_command_coprocessor.sv
